### rtl/sk_pkg.sv
// Shared constants and types for the scalar Kalman filter block.
`timescale 1ns / 1ps

package sk_pkg;

   // Default widths of the sample and of the estimate fraction.
   localparam int SAMPLE_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF   = 16;

   // Noise and covariance registers are unsigned 8.16, 24 bits wide.
   localparam int REG_BITS  = 24;
   localparam int DEN_BITS  = REG_BITS + 1;
   localparam int GAIN_BITS = 16;
   localparam int GAIN_W    = GAIN_BITS + 1;
   localparam int STEP_BITS = $clog2(GAIN_W);

   localparam logic [GAIN_W-1:0]   GAIN_ONE = GAIN_W'(1) << GAIN_BITS;
   localparam logic [REG_BITS-1:0] REG_MAX  = '1;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROCESS_NOISE      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MEASUREMENT_NOISE  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INITIAL_COVARIANCE = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [REG_BITS-1:0] PROCESS_NOISE_RST      = 24'd0;
   localparam logic [REG_BITS-1:0] MEASUREMENT_NOISE_RST  = 24'd655;
   localparam logic [REG_BITS-1:0] INITIAL_COVARIANCE_RST = 24'd65536;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } state_type;

endpackage

### rtl/scalar_kalman_filter.sv
// Scalar Kalman filter with a bit-serial divider and shift-add multipliers.
`timescale 1ns / 1ps

// Usage
// A request carries one converter sample on req_sample; it is taken at a clock edge
// where req_valid is high and req_stall is low. Each request gives exactly one
// response: rsp_estimate (new estimate, fraction dropped) and rsp_gain (Q1.16 gain,
// 65536 is 1.0), held on the rsp_ ports while rsp_valid is high and rsp_stall is high.
// The filter works on one request at a time. The gain division makes one quotient
// bit per cycle and the two multiplies then take one gain bit per cycle side by side,
// between a setup step and an update step; the next request waits for the idle state.
// The response sits in its own register, so a stalled receiver does not hold up work
// on the next request until that request's result is ready; the state update then
// waits for the register to free up.
// The csr_ channel writes process noise, measurement noise and initial covariance
// (index 0, 1, 2); csr_ready is always high and writing index 2 also reloads the
// covariance. The user is to make writes only while the filter is idle; the block
// itself does not enforce this. The synchronous reset clears the estimate, loads
// the register defaults and sets covariance to 1.0.
module scalar_kalman_filter #(
   parameter int SAMPLE_BITS = sk_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = sk_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [SAMPLE_BITS-1:0]               req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [SAMPLE_BITS-1:0]               rsp_estimate,
   output logic [sk_pkg::GAIN_W-1:0]            rsp_gain,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sk_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sk_pkg::REG_BITS-1:0]          csr_data
);

   // The estimate accumulator is SAMPLE_BITS.FRAC_BITS unsigned.
   localparam int ACC_BITS  = SAMPLE_BITS + FRAC_BITS;
   localparam int REG_BITS  = sk_pkg::REG_BITS;
   localparam int DEN_BITS  = sk_pkg::DEN_BITS;
   localparam int GAIN_W    = sk_pkg::GAIN_W;
   localparam int STEP_BITS = sk_pkg::STEP_BITS;
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(sk_pkg::GAIN_BITS);

   // Control and architectural state.
   sk_pkg::state_type     state_ff, state_in;
   logic [STEP_BITS-1:0]  cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [REG_BITS-1:0]   pnoise_ff, pnoise_in;
   logic [REG_BITS-1:0]   mnoise_ff, mnoise_in;
   logic [REG_BITS-1:0]   pinit_ff, pinit_in;
   logic [REG_BITS-1:0]   cov_ff, cov_in;
   logic [ACC_BITS-1:0]   est_ff, est_in;

   // Datapath registers of the request in flight.
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [REG_BITS-1:0]    pred_ff, pred_in;
   logic [DEN_BITS-1:0]    den_ff, den_in;
   logic                   zero_den_ff, zero_den_in;
   logic [DEN_BITS-1:0]    rem_ff, rem_in;
   logic [GAIN_W-1:0]      gain_ff, gain_in;
   logic [GAIN_W-1:0]      mk_ff, mk_in;
   logic [GAIN_W-1:0]      mc_ff, mc_in;
   logic [ACC_BITS-1:0]    mag_ff, mag_in;
   logic                   up_ff, up_in;
   logic [ACC_BITS-1:0]    pa_ff, pa_in;
   logic [REG_BITS-1:0]    pc_ff, pc_in;
   logic [SAMPLE_BITS-1:0] rsp_est_ff, rsp_est_in;
   logic [GAIN_W-1:0]      rsp_gain_ff, rsp_gain_in;

   // Combinational helpers.
   logic [DEN_BITS-1:0]   pred_sum;
   logic [ACC_BITS-1:0]   target;
   logic [DEN_BITS:0]     rem_shift;
   logic [DEN_BITS-1:0]   rem_diff;
   logic                  rem_ge;
   logic [GAIN_W-1:0]     quo_next;
   logic [ACC_BITS:0]     a_sum;
   logic [DEN_BITS-1:0]   c_sum;
   logic                  out_free;
   logic                  req_accept;

   assign req_stall  = (state_ff != sk_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_estimate = rsp_est_ff;
   assign rsp_gain     = rsp_gain_ff;

   // Predicted covariance P + Q, saturated at the register maximum.
   assign pred_sum = {1'b0, cov_ff} + {1'b0, pnoise_ff};
   assign target   = {sample_ff, {FRAC_BITS{1'b0}}};

   // Restoring divider step. The first step tests the integer bit of P'/(P'+R)
   // without a shift; every later step doubles the partial remainder first.
   // When the test passes the difference is below the divisor, so its low bits
   // are exact.
   assign rem_shift = (cnt_ff == LAST_STEP) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign rem_diff  = rem_shift[DEN_BITS-1:0] - den_ff;
   assign rem_ge    = (rem_shift >= {1'b0, den_ff});
   assign quo_next  = {gain_ff[GAIN_W-2:0], rem_ge};

   // Shift-add multiplier steps, one multiplier bit per cycle, LSB first.
   assign a_sum = {1'b0, pa_ff} + (mk_ff[0] ? {1'b0, mag_ff} : '0);
   assign c_sum = {1'b0, pc_ff} + (mc_ff[0] ? {1'b0, pred_ff} : '0);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      pnoise_in    = pnoise_ff;
      mnoise_in    = mnoise_ff;
      pinit_in     = pinit_ff;
      cov_in       = cov_ff;
      est_in       = est_ff;
      sample_in    = sample_ff;
      pred_in      = pred_ff;
      den_in       = den_ff;
      zero_den_in  = zero_den_ff;
      rem_in       = rem_ff;
      gain_in      = gain_ff;
      mk_in        = mk_ff;
      mc_in        = mc_ff;
      mag_in       = mag_ff;
      up_in        = up_ff;
      pa_in        = pa_ff;
      pc_in        = pc_ff;
      rsp_est_in   = rsp_est_ff;
      rsp_gain_in  = rsp_gain_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sk_pkg::ST_IDLE: begin
            if (req_accept) begin
               sample_in = req_sample;
               pred_in   = pred_sum[REG_BITS] ? sk_pkg::REG_MAX : pred_sum[REG_BITS-1:0];
               state_in  = sk_pkg::ST_PREP;
            end
         end
         sk_pkg::ST_PREP: begin
            den_in      = {1'b0, pred_ff} + {1'b0, mnoise_ff};
            zero_den_in = (pred_ff == '0) && (mnoise_ff == '0);
            rem_in      = {1'b0, pred_ff};
            gain_in     = '0;
            up_in       = (target >= est_ff);
            mag_in      = (target >= est_ff) ? (target - est_ff) : (est_ff - target);
            cnt_in      = LAST_STEP;
            state_in    = sk_pkg::ST_DIV;
         end
         sk_pkg::ST_DIV: begin
            rem_in  = rem_ge ? rem_diff : rem_shift[DEN_BITS-1:0];
            gain_in = quo_next;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               // A zero denominator forces the gain to 1.0.
               gain_in  = zero_den_ff ? sk_pkg::GAIN_ONE : quo_next;
               mk_in    = zero_den_ff ? sk_pkg::GAIN_ONE : quo_next;
               mc_in    = sk_pkg::GAIN_ONE - (zero_den_ff ? sk_pkg::GAIN_ONE : quo_next);
               pa_in    = '0;
               pc_in    = '0;
               cnt_in   = LAST_STEP;
               state_in = sk_pkg::ST_MUL;
            end
         end
         sk_pkg::ST_MUL: begin
            mk_in  = mk_ff >> 1;
            mc_in  = mc_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               // The top gain bit carries weight 2^16, so no shift follows it.
               pa_in    = a_sum[ACC_BITS-1:0];
               pc_in    = c_sum[REG_BITS-1:0];
               state_in = sk_pkg::ST_DONE;
            end else begin
               pa_in = a_sum[ACC_BITS:1];
               pc_in = c_sum[REG_BITS:1];
            end
         end
         sk_pkg::ST_DONE: begin
            if (out_free) begin
               est_in       = up_ff ? (est_ff + pa_ff) : (est_ff - pa_ff);
               cov_in       = pc_ff;
               rsp_est_in   = est_in[ACC_BITS-1:FRAC_BITS];
               rsp_gain_in  = gain_ff;
               rsp_valid_in = 1'b1;
               state_in     = sk_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sk_pkg::ST_IDLE;
         end
      endcase

      if (csr_valid) begin
         case (csr_index)
            sk_pkg::CSR_PROCESS_NOISE: begin
               pnoise_in = csr_data;
            end
            sk_pkg::CSR_MEASUREMENT_NOISE: begin
               mnoise_in = csr_data;
            end
            sk_pkg::CSR_INITIAL_COVARIANCE: begin
               pinit_in = csr_data;
               cov_in   = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sk_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pnoise_ff    <= sk_pkg::PROCESS_NOISE_RST;
         mnoise_ff    <= sk_pkg::MEASUREMENT_NOISE_RST;
         pinit_ff     <= sk_pkg::INITIAL_COVARIANCE_RST;
         cov_ff       <= sk_pkg::INITIAL_COVARIANCE_RST;
         est_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         pnoise_ff    <= pnoise_in;
         mnoise_ff    <= mnoise_in;
         pinit_ff     <= pinit_in;
         cov_ff       <= cov_in;
         est_ff       <= est_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      pred_ff     <= pred_in;
      den_ff      <= den_in;
      zero_den_ff <= zero_den_in;
      rem_ff      <= rem_in;
      gain_ff     <= gain_in;
      mk_ff       <= mk_in;
      mc_ff       <= mc_in;
      mag_ff      <= mag_in;
      up_ff       <= up_in;
      pa_ff       <= pa_in;
      pc_ff       <= pc_in;
      rsp_est_ff  <= rsp_est_in;
      rsp_gain_ff <= rsp_gain_in;
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == sk_pkg::ST_PREP)
      else $error("accepted request did not start the setup step");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == sk_pkg::ST_DONE)
      else $error("response appeared without a finished update");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gain <= sk_pkg::GAIN_ONE)
      else $error("gain above 1.0");

   a_zero_den_gain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sk_pkg::ST_DONE && zero_den_ff) |-> gain_ff == sk_pkg::GAIN_ONE)
      else $error("zero denominator did not force unit gain");

   a_cov_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == sk_pkg::ST_DONE |-> pc_ff <= pred_ff)
      else $error("updated covariance exceeds predicted covariance");
`endif

endmodule

### verif/tb_top.sv
// Self-checking testbench for the scalar Kalman filter with its own filter predictor.
`timescale 1ns / 1ps

module tb_top;

   // Widths of the default build of the filter.
   localparam int SAMPLE_W       = sk_pkg::SAMPLE_BITS_DEF;
   localparam int FRAC_W         = sk_pkg::FRAC_BITS_DEF;
   localparam int ACC_W          = SAMPLE_W + FRAC_W;
   localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
   localparam int REG_BITS       = sk_pkg::REG_BITS;
   localparam int GAIN_W         = sk_pkg::GAIN_W;
   localparam int GAIN_BITS      = sk_pkg::GAIN_BITS;
   localparam int CSR_INDEX_BITS = sk_pkg::CSR_INDEX_BITS;

   // The csr index that no register answers to; a write there must change nothing.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 2'd3;

   // Lengths of the waits and of the test phases.
   localparam int LATENCY         = 40;
   localparam int SETTLE_CYCLES   = 4;
   localparam int PHASES          = 7;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int HOLD_PHASE      = 2;
   localparam int LONG_HOLD       = 300;

   typedef struct packed {
      logic [SAMPLE_W-1:0] estimate;
      logic [GAIN_W-1:0]   gain;
   } filter_out_type;

   typedef enum {SIG_NEAR_LEVEL, SIG_UNIFORM, SIG_RAIL} signal_kind_type;

   // The scoreboard carries its own copy of the filter state and of the noise
   // registers, and turns every accepted sample into the estimate and gain it expects.
   class kalman_scoreboard_type;
      logic [REG_BITS-1:0] process_noise;
      logic [REG_BITS-1:0] measurement_noise;
      logic [REG_BITS-1:0] initial_cov;
      logic [ACC_W-1:0]    estimate_acc;
      logic [REG_BITS-1:0] covariance;
      filter_out_type      expected_outputs[$];
      int                  mismatches;

      function new();
         process_noise     = sk_pkg::PROCESS_NOISE_RST;
         measurement_noise = sk_pkg::MEASUREMENT_NOISE_RST;
         initial_cov       = sk_pkg::INITIAL_COVARIANCE_RST;
         estimate_acc      = '0;
         covariance        = sk_pkg::INITIAL_COVARIANCE_RST;
         mismatches        = 0;
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction

      // Writing the initial covariance also reloads the running covariance.
      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [REG_BITS-1:0] value);
         case (index)
            sk_pkg::CSR_PROCESS_NOISE:      process_noise = value;
            sk_pkg::CSR_MEASUREMENT_NOISE:  measurement_noise = value;
            sk_pkg::CSR_INITIAL_COVARIANCE: begin
               initial_cov = value;
               covariance  = value;
            end
            default: ;
         endcase
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] sample);
         bit [63:0]      predicted;
         bit [63:0]      denom;
         bit [63:0]      gain;
         bit [63:0]      target;
         bit [63:0]      current;
         filter_out_type result;
         // Predicted covariance saturates at the register maximum.
         predicted = 64'(covariance) + 64'(process_noise);
         if (predicted > 64'(sk_pkg::REG_MAX)) predicted = 64'(sk_pkg::REG_MAX);
         // Gain is the truncated quotient, forced to one on a zero denominator.
         denom = predicted + 64'(measurement_noise);
         if (denom == 0) gain = 64'(sk_pkg::GAIN_ONE);
         else gain = (predicted << GAIN_BITS) / denom;
         if (gain > 64'(sk_pkg::GAIN_ONE)) gain = 64'(sk_pkg::GAIN_ONE);
         // The step toward the sample is truncated toward zero in both directions.
         target  = 64'(sample) << FRAC_W;
         current = 64'(estimate_acc);
         if (target >= current) current = current + (((target - current) * gain) >> GAIN_BITS);
         else current = current - (((current - target) * gain) >> GAIN_BITS);
         estimate_acc = current[ACC_W-1:0];
         covariance   = REG_BITS'(((64'(sk_pkg::GAIN_ONE) - gain) * predicted) >> GAIN_BITS);
         result.estimate = estimate_acc[ACC_W-1 -: SAMPLE_W];
         result.gain     = gain[GAIN_W-1:0];
         expected_outputs.push_back(result);
      endfunction

      function void check_output(logic [SAMPLE_W-1:0] estimate, logic [GAIN_W-1:0] gain);
         filter_out_type want;
         if (expected_outputs.size() == 0) begin
            $error("response with no request outstanding: estimate %0d, gain %0d",
                   estimate, gain);
            mismatches++;
         end else begin
            want = expected_outputs.pop_front();
            if (estimate !== want.estimate) begin
               $error("estimate mismatch: expected %0d, actual %0d", want.estimate, estimate);
               mismatches++;
            end
            if (gain !== want.gain) begin
               $error("gain mismatch: expected %0d, actual %0d", want.gain, gain);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [SAMPLE_W-1:0]       req_sample;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [SAMPLE_W-1:0]       rsp_estimate;
   logic [GAIN_W-1:0]         rsp_gain;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [REG_BITS-1:0]       csr_data;

   // Set by the stimulus to make the receiver hold off once for a long stretch.
   logic long_hold;

   kalman_scoreboard_type book = new();

   scalar_kalman_filter u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_estimate (rsp_estimate),
      .rsp_gain     (rsp_gain),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // All inputs change by nonblocking assignment at the rising edge, so values read
   // here at the edge are the ones the filter itself sees on that edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) book.note_sample(req_sample);
         if (rsp_valid && !rsp_stall) book.check_output(rsp_estimate, rsp_gain);
         if (csr_valid && csr_ready) book.write_register(csr_index, csr_data);
      end
   end

   // The receiver runs stretches of random length, each with its own stall rate:
   // no stalls at all, light stalls or heavy stalls. On request it holds off once for
   // a long stretch so that the response register fills and the filter stalls requests.
   initial begin
      int stretch_left;
      int stall_pct;
      bit hold_done;
      stretch_left = 0;
      stall_pct    = 0;
      hold_done    = 1'b0;
      rsp_stall    = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
            rsp_stall <= 1'b0;
         end else begin
            if (stretch_left == 0) begin
               case ($urandom_range(0, 2))
                  0:       stall_pct = 0;
                  1:       stall_pct = 25;
                  default: stall_pct = 75;
               endcase
               stretch_left = $urandom_range(20, 200);
            end
            stretch_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Offers one sample and returns at the edge where the filter takes it. Valid is
   // left high so that a burst goes on without a dead cycle.
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Stops offering requests and waits until every expected response is in.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [REG_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes the registers picked by the mask, lowest index first; the top bit of the
   // mask picks the unused index, whose write the filter must ignore.
   task automatic configure(input logic [3:0] which,
                            input logic [REG_BITS-1:0] q, r, p0, junk);
      if (which[0]) csr_write(sk_pkg::CSR_PROCESS_NOISE, q);
      if (which[1]) csr_write(sk_pkg::CSR_MEASUREMENT_NOISE, r);
      if (which[2]) csr_write(sk_pkg::CSR_INITIAL_COVARIANCE, p0);
      if (which[3]) csr_write(CSR_UNUSED_INDEX, junk);
      csr_valid <= 1'b0;
   endtask

   // Noise values lean to the ends of the range and to small, realistic values.
   function automatic logic [REG_BITS-1:0] pick_noise();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return sk_pkg::REG_MAX;
         2, 3:    return REG_BITS'($urandom_range(0, 8192));
         4:       return REG_BITS'($urandom_range(0, 24'h0FFFFF));
         default: return REG_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] make_sample(signal_kind_type kind, int level);
      int value;
      case (kind)
         SIG_UNIFORM: value = $urandom_range(0, SAMPLE_MAX);
         SIG_RAIL:    value = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
         default:     value = level + int'($urandom_range(0, 64)) - 32;
      endcase
      if (value < 0) value = 0;
      if (value > SAMPLE_MAX) value = SAMPLE_MAX;
      return value[SAMPLE_W-1:0];
   endfunction

   initial begin
      int              sent;
      int              burst;
      int              gap;
      int              level;
      signal_kind_type kind;

      reset      = 1'b1;
      long_hold  = 1'b0;
      req_valid  = 1'b0;
      req_sample = '0;
      csr_valid  = 1'b0;
      csr_index  = sk_pkg::CSR_PROCESS_NOISE;
      csr_data   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: the estimate climbs from zero toward full scale and back.
      send_sample(12'd4095);
      send_sample(12'd0);
      send_sample(12'd4095);
      send_sample(12'd2048);
      send_sample(12'd0);
      wait_until_idle();

      // Both noise terms and the covariance at their maximum: the predicted
      // covariance saturates and the gain ends up close to one half.
      configure(4'b0111, sk_pkg::REG_MAX, sk_pkg::REG_MAX, sk_pkg::REG_MAX, '0);
      send_sample(12'd100);
      send_sample(12'd200);
      wait_until_idle();

      // No measurement noise: the gain reaches exactly one and the estimate
      // jumps straight to each sample.
      configure(4'b0011, sk_pkg::REG_MAX, '0, '0, '0);
      send_sample(12'd4095);
      send_sample(12'd0);
      send_sample(12'd1234);
      wait_until_idle();

      // Everything zero: the denominator is zero and the gain is forced to one.
      configure(4'b0111, '0, '0, '0, '0);
      send_sample(12'd0);
      send_sample(12'd4095);
      send_sample(12'd5);
      wait_until_idle();

      // Huge measurement noise against a tiny covariance: the gain is near zero
      // and the truncated step leaves the estimate where it was.
      configure(4'b0111, '0, sk_pkg::REG_MAX, 24'd1, '0);
      send_sample(12'd4095);
      send_sample(12'd4095);
      send_sample(12'd0);
      wait_until_idle();

      // Equal tiny terms give a gain of one half, which shows step truncation.
      configure(4'b0111, 24'd1, 24'd1, '0, '0);
      send_sample(12'd4095);
      send_sample(12'd0);
      send_sample(12'd4095);
      send_sample(12'd1);
      wait_until_idle();

      // A write to the unused index must leave every register alone.
      configure(4'b1000, '0, '0, '0, sk_pkg::REG_MAX);
      send_sample(12'd3000);
      send_sample(12'd3001);
      wait_until_idle();

      // Random phases, each under its own register setting. Most samples follow a
      // slowly drifting level with noise, as a converter would deliver; the rest are
      // uniform over the range or pinned to the rails.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_until_idle();
         configure(4'($urandom_range(0, 15)), pick_noise(), pick_noise(), pick_noise(),
                   REG_BITS'($urandom));
         if (phase == HOLD_PHASE) long_hold <= 1'b1;
         level = $urandom_range(0, SAMPLE_MAX);
         sent  = 0;
         while (sent < ITEMS_PER_PHASE) begin
            burst = $urandom_range(1, 12);
            case ($urandom_range(0, 9))
               7:       kind = SIG_UNIFORM;
               8:       kind = SIG_RAIL;
               default: kind = SIG_NEAR_LEVEL;
            endcase
            if ($urandom_range(0, 9) == 0) level = $urandom_range(0, SAMPLE_MAX);
            for (int b = 0; b < burst && sent < ITEMS_PER_PHASE; b++) begin
               send_sample(make_sample(kind, level));
               sent++;
               level = level + int'($urandom_range(0, 16)) - 8;
               if (level < 0) level = 0;
               if (level > SAMPLE_MAX) level = SAMPLE_MAX;
            end
            // While the receiver holds off, keep requests coming back to back so
            // that the filter has to stall the sender.
            if (phase == HOLD_PHASE && sent < 40) gap = 0;
            else if ($urandom_range(0, 9) < 3) gap = 0;
            else gap = $urandom_range(1, 80);
            pause_sender(gap);
         end
      end

      wait_until_idle();
      repeat (LATENCY) @(posedge clock);
      if (book.mismatches == 0 && book.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Far beyond the slowest correct run, even with every stall at its longest.
   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
